// ===== rtl/core/abox_pkg.sv =====
// ============================================================================
// abox_pkg
// Shared types and constants for the 4D box and sphere fold iteration.
// ============================================================================
`default_nettype none

package abox_pkg;

    localparam int DIV_BITS   = 47;
    localparam int REG_IDX_W  = 3;
    localparam int DATA_BYTES = 29;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FOLD_LIMIT   = 3'd0,
        REG_MIN_R2       = 3'd1,
        REG_FIXED_R2     = 3'd2,
        REG_BASE_SCALE   = 3'd3,
        REG_SCALE_VARY   = 3'd4,
        REG_COLOR_FOLD   = 3'd5,
        REG_COLOR_INNER  = 3'd6,
        REG_COLOR_OUTER  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [3:0][31:0] pos;
        logic [39:0]      deriv;
        logic [31:0]      scale;
        logic [31:0]      color;
        logic             sphere;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/abox_div.sv =====
// ============================================================================
// abox_div
// Pipelined restoring divider, one quotient bit per stage, with a payload
// that travels alongside each item.
// ============================================================================
`default_nettype none

module abox_div
    import abox_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [DIV_BITS-1:0] in_num,
    input  logic [30:0]         in_den,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [DIV_BITS-1:0] out_quot,
    output side_t               out_side
);

    logic                valid_reg [DIV_BITS];
    logic [DIV_BITS-1:0] num_reg   [DIV_BITS];
    logic [DIV_BITS-1:0] quot_reg  [DIV_BITS];
    logic [30:0]         rem_reg   [DIV_BITS];
    logic [30:0]         den_reg   [DIV_BITS];
    side_t               side_reg  [DIV_BITS];

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
        logic                v_in;
        logic [DIV_BITS-1:0] n_in;
        logic [DIV_BITS-1:0] q_in;
        logic [30:0]         r_in;
        logic [30:0]         d_in;
        side_t               s_in;
        logic [31:0]         trial;
        logic                fits;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = in_num;
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = in_den;
            assign s_in = in_side;
        end
        else begin : g_next
            assign v_in = valid_reg[i-1];
            assign n_in = num_reg[i-1];
            assign q_in = quot_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign d_in = den_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        assign trial = {r_in, n_in[DIV_BITS-1]};
        assign fits  = (trial >= {1'b0, d_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (ce)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                num_reg[i]  <= {n_in[DIV_BITS-2:0], 1'b0};
                quot_reg[i] <= {q_in[DIV_BITS-2:0], fits};
                rem_reg[i]  <= fits ? 31'(trial - {1'b0, d_in}) : trial[30:0];
                den_reg[i]  <= d_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_BITS-1];
    assign out_quot  = quot_reg[DIV_BITS-1];
    assign out_side  = side_reg[DIV_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/abox_4d_fold_iteration.sv =====
// ============================================================================
// abox_4d_fold_iteration
// One 4D box fold, sphere fold and scale iteration in Q16.16 fixed point.
// ============================================================================
// Channel   Direction  Signals                        Contents
// s_*       in         s_tvalid s_tready s_tdata     point, deriv, scale, color
// m_*       out        m_tvalid m_tready m_tdata     new point, deriv, scale, color
// cfg_*     in         cfg_wr_en cfg_index cfg_data  register writes
//
// One item enters per cycle unless a waiting result stalls the pipeline.
// The sphere factor comes from the 47-stage pipelined divider.
// The whole pipeline holds as one when a result waits and m_tready is low.
// Reset clears the valid bits and loads the register defaults.
// ============================================================================
`default_nettype none

module abox_4d_fold_iteration
    import abox_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pos_x, pos_y, pos_z, pos_w, deriv_in, scale_in, color_in
    input  logic [DATA_BYTES*8-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // new_x, new_y, new_z, new_w, deriv_out, scale_out, color_out
    output logic [DATA_BYTES*8-1:0]  m_tdata
);

    localparam logic [39:0] DERIV_MAX = 40'hFF_FFFF_FFFF;

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > 72'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -72'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // Signed result from a magnitude capped at 2^31.
    function automatic logic [31:0] signed_cap(input logic [63:0] mag, input logic neg);
        logic [32:0]        m;
        logic signed [33:0] s;
        m = (mag > 64'h8000_0000) ? 33'h0_8000_0000 : mag[32:0];
        s = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return sat32(72'(s));
    endfunction

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Configuration registers.
    logic [30:0] fold_limit_reg, min_r2_reg, fixed_r2_reg;
    logic [31:0] base_scale_reg, scale_vary_reg;
    logic [30:0] color_fold_reg, color_inner_reg, color_outer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_limit_reg  <= 31'd65536;
            min_r2_reg      <= 31'd16384;
            fixed_r2_reg    <= 31'd65536;
            base_scale_reg  <= 32'd131072;
            scale_vary_reg  <= 32'd0;
            color_fold_reg  <= 31'd65536;
            color_inner_reg <= 31'd65536;
            color_outer_reg <= 31'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOLD_LIMIT:  fold_limit_reg  <= cfg_data[30:0];
                REG_MIN_R2:      min_r2_reg      <= cfg_data[30:0];
                REG_FIXED_R2:    fixed_r2_reg    <= cfg_data[30:0];
                REG_BASE_SCALE:  base_scale_reg  <= cfg_data;
                REG_SCALE_VARY:  scale_vary_reg  <= cfg_data;
                REG_COLOR_FOLD:  color_fold_reg  <= cfg_data[30:0];
                REG_COLOR_INNER: color_inner_reg <= cfg_data[30:0];
                REG_COLOR_OUTER: color_outer_reg <= cfg_data[30:0];
            endcase
        end
    end

    // Valid bits of the stages outside the divider.
    logic v1_reg, v2_reg, v3_reg, v4_reg, vm1_reg, vm2_reg, vm3_reg, vm4_reg;
    logic div_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
            vm4_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            vm1_reg <= div_valid;
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
            vm4_reg <= vm3_reg;
        end
    end

    // Stage 1: box fold and scale offset.
    logic [3:0][31:0]   p1_next, p1_reg;
    logic [2:0]         fcnt1_next, fcnt1_reg;
    logic signed [33:0] t1_next, t1_reg;
    logic [39:0]        d1_reg;
    logic [31:0]        c1_reg;

    always_comb
    begin
        logic signed [33:0] lim, lim2, z, f, sin, sab;
        lim        = $signed({3'b0, fold_limit_reg});
        lim2       = $signed({2'b0, fold_limit_reg, 1'b0});
        fcnt1_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            z = 34'($signed(s_tdata[32*k +: 32]));
            if (z > lim)
            begin
                f = lim2 - z;
            end
            else if (z < -lim)
            begin
                f = -lim2 - z;
            end
            else
            begin
                f = z;
            end
            if (f != z)
            begin
                fcnt1_next = fcnt1_next + 3'd1;
            end
            p1_next[k] = sat32(72'(f));
        end
        sin     = 34'($signed(s_tdata[199:168]));
        sab     = (sin < 0) ? -sin : sin;
        t1_next = sab - 34'sd65536;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg    <= p1_next;
            fcnt1_reg <= fcnt1_next;
            t1_reg    <= t1_next;
            d1_reg    <= s_tdata[167:128];
            c1_reg    <= s_tdata[231:200];
        end
    end

    // Stage 2: squares and scale product.
    logic [3:0][63:0] sq2_reg;
    logic [63:0]      sp2_reg;
    logic             sn2_reg;
    logic [3:0][31:0] p2_reg;
    logic [2:0]       fcnt2_reg;
    logic [39:0]      d2_reg;
    logic [31:0]      c2_reg;
    logic [31:0]      t1_abs;

    assign t1_abs = t1_reg[33] ? 32'(-t1_reg) : t1_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq2_reg[k] <= {32'b0, abs32(p1_reg[k])} * {32'b0, abs32(p1_reg[k])};
            end
            sp2_reg   <= {32'b0, abs32(scale_vary_reg)} * {32'b0, t1_abs};
            sn2_reg   <= scale_vary_reg[31] != t1_reg[33];
            p2_reg    <= p1_reg;
            fcnt2_reg <= fcnt1_reg;
            d2_reg    <= d1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // Stage 3: squared length, new scale, fold colour.
    logic [47:0]        rr3_next, rr3_reg;
    logic [31:0]        sc3_next, sc3_reg;
    logic [33:0]        af3_reg;
    logic [3:0][31:0]   p3_reg;
    logic [39:0]        d3_reg;
    logic [31:0]        c3_reg;

    always_comb
    begin
        logic [65:0]        sum;
        logic [40:0]        term;
        logic signed [42:0] st;
        sum      = 66'(sq2_reg[0]) + 66'(sq2_reg[1]) + 66'(sq2_reg[2]) + 66'(sq2_reg[3]);
        rr3_next = (sum[65:64] != 2'b0) ? 48'hFFFF_FFFF_FFFF : sum[63:16];
        term     = (sp2_reg[63:16] > 48'h100_0000_0000) ? 41'h100_0000_0000
                                                        : sp2_reg[56:16];
        st       = sn2_reg ? -$signed({2'b0, term}) : $signed({2'b0, term});
        sc3_next = sat32(72'(43'($signed(base_scale_reg)) + st));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rr3_reg <= rr3_next;
            sc3_reg <= sc3_next;
            af3_reg <= 34'(fcnt2_reg) * 34'(color_fold_reg);
            p3_reg  <= p2_reg;
            d3_reg  <= d2_reg;
            c3_reg  <= c2_reg;
        end
    end

    // Stage 4: sphere case, divisor choice, final colour.
    logic                inner4, outer4;
    logic [30:0]         den4_next, den4_reg;
    logic [DIV_BITS-1:0] num4_reg;
    side_t               side4_next, side4_reg;

    always_comb
    begin
        logic [34:0] add;
        logic [35:0] csum;
        inner4    = rr3_reg < {17'b0, min_r2_reg};
        outer4    = !inner4 && (rr3_reg < {17'b0, fixed_r2_reg});
        den4_next = inner4 ? min_r2_reg : ((rr3_reg == '0) ? 31'd1 : rr3_reg[30:0]);
        add       = 35'(af3_reg) + (inner4 ? 35'(color_inner_reg)
                                           : (outer4 ? 35'(color_outer_reg) : 35'd0));
        csum      = 36'(c3_reg) + 36'(add);
        side4_next.pos    = p3_reg;
        side4_next.deriv  = d3_reg;
        side4_next.scale  = sc3_reg;
        side4_next.color  = (csum[35:32] != 4'b0) ? 32'hFFFF_FFFF : csum[31:0];
        side4_next.sphere = inner4 || outer4;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den4_reg  <= den4_next;
            num4_reg  <= {fixed_r2_reg, 16'b0};
            side4_reg <= side4_next;
        end
    end

    // Sphere factor.
    logic [DIV_BITS-1:0] div_quot;
    side_t               div_side;

    abox_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // M1: partial products of the sphere factor.
    logic [3:0][62:0] ph1_reg;
    logic [3:0][47:0] pl1_reg;
    logic [38:0]      dhh1_reg;
    logic [62:0]      dlh1_reg;
    logic [23:0]      dhl1_reg;
    logic [47:0]      dll1_reg;
    side_t            sm1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ph1_reg[k] <= 63'(abs32(div_side.pos[k])) * 63'(div_quot[46:16]);
                pl1_reg[k] <= 48'(abs32(div_side.pos[k])) * 48'(div_quot[15:0]);
            end
            dhh1_reg <= 39'(div_side.deriv[39:32]) * 39'(div_quot[46:16]);
            dlh1_reg <= 63'(div_side.deriv[31:0]) * 63'(div_quot[46:16]);
            dhl1_reg <= 24'(div_side.deriv[39:32]) * 24'(div_quot[15:0]);
            dll1_reg <= 48'(div_side.deriv[31:0]) * 48'(div_quot[15:0]);
            sm1_reg  <= div_side;
        end
    end

    // M2: sphere-folded point and derivative.
    logic [3:0][31:0] v2_next;
    logic [39:0]      dm2_next;
    side_t            sm2_reg;
    logic [3:0][31:0] vm2_pos_reg;
    logic [39:0]      dm2_reg;

    always_comb
    begin
        logic [63:0] mag;
        logic [71:0] full;
        for (int k = 0; k < 4; k++)
        begin
            mag        = 64'(ph1_reg[k]) + 64'(pl1_reg[k][47:16]);
            v2_next[k] = sm1_reg.sphere ? signed_cap(mag, sm1_reg.pos[k][31])
                                        : sm1_reg.pos[k];
        end
        full = (72'(dhh1_reg) << 32) + 72'(dlh1_reg)
             + ((72'(dll1_reg) + (72'(dhl1_reg) << 32)) >> 16);
        if (!sm1_reg.sphere)
        begin
            dm2_next = sm1_reg.deriv;
        end
        else if (full > 72'(DERIV_MAX))
        begin
            dm2_next = DERIV_MAX;
        end
        else
        begin
            dm2_next = full[39:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vm2_pos_reg <= v2_next;
            dm2_reg     <= dm2_next;
            sm2_reg     <= sm1_reg;
        end
    end

    // M3: products with the new scale.
    logic [31:0]      sabs3;
    logic [3:0][63:0] pm3_reg;
    logic [3:0]       nm3_reg;
    logic [63:0]      dl3_reg;
    logic [39:0]      dh3_reg;
    logic [31:0]      sc_m3_reg, c_m3_reg;

    assign sabs3 = abs32(sm2_reg.scale);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pm3_reg[k] <= {32'b0, abs32(vm2_pos_reg[k])} * {32'b0, sabs3};
                nm3_reg[k] <= vm2_pos_reg[k][31] != sm2_reg.scale[31];
            end
            dl3_reg   <= {32'b0, dm2_reg[31:0]} * {32'b0, sabs3};
            dh3_reg   <= 40'(dm2_reg[39:32]) * 40'(sabs3);
            sc_m3_reg <= sm2_reg.scale;
            c_m3_reg  <= sm2_reg.color;
        end
    end

    // M4: final scaling, derivative offset and output register.
    logic [3:0][31:0] q4_next, q4_reg;
    logic [39:0]      d4_next, d4_reg;
    logic [31:0]      sc4_reg, c4_reg;

    always_comb
    begin
        logic [71:0] full;
        logic [39:0] capd;
        for (int k = 0; k < 4; k++)
        begin
            q4_next[k] = signed_cap({16'b0, pm3_reg[k][63:16]}, nm3_reg[k]);
        end
        full = (72'(dh3_reg) << 32) + 72'(dl3_reg);
        capd = (full[71:16] > 56'(DERIV_MAX)) ? DERIV_MAX : full[55:16];
        d4_next = (capd > DERIV_MAX - 40'd65536) ? DERIV_MAX : capd + 40'd65536;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q4_reg  <= q4_next;
            d4_reg  <= d4_next;
            sc4_reg <= sc_m3_reg;
            c4_reg  <= c_m3_reg;
        end
    end

    assign m_tvalid = vm4_reg;
    assign m_tdata  = {c4_reg, sc4_reg, d4_reg, q4_reg[3], q4_reg[2], q4_reg[1], q4_reg[0]};

    // The output derivative is always at least one unit.
    a_deriv_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (d4_reg >= 40'd65536))
        else $error("derivative below one");

    // A stall freezes the divider output.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(div_valid) && $stable(div_quot))
        else $error("divider moved during stall");

    // Without a waiting result the block always takes items.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // The two sphere cases never both apply to one item.
    a_sphere_case: assert property (@(posedge clk) disable iff (!rst_n)
        !(inner4 && outer4))
        else $error("both sphere cases taken");

endmodule

`default_nettype wire

// ===== sim/abox_4d_fold_iteration_tb.sv =====
// ============================================================================
// abox_4d_fold_iteration_tb
// Self-checking testbench for the 4D box and sphere fold iteration. Items are
// streamed in with random gaps while the output side stalls at random. Every
// accepted item is run through a local fixed-point predictor, and each result
// is checked field by field against the oldest prediction.
// ============================================================================
`default_nettype none

module abox_4d_fold_iteration_tb;
    import abox_pkg::*;

    localparam int DW = DATA_BYTES * 8;
    localparam int LATENCY = 55;
    localparam longint unsigned DERIV_MAX = 64'hFF_FFFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DW-1:0]        s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DW-1:0]        m_tdata;

    longint unsigned lim_reg, min_r2_reg, fixed_r2_reg;
    longint          base_scale_reg, scale_vary_reg;
    longint unsigned col_fold_reg, col_inner_reg, col_outer_reg;

    logic [DW-1:0] iteration_q[$];
    int            err_count;
    int            hold_req;
    bit            sender_steady;
    bit            receiver_steady;

    const int    fld_lo[7] = '{0, 32, 64, 96, 128, 168, 200};
    const int    fld_w[7]  = '{32, 32, 32, 32, 40, 32, 32};
    const string fld_name[7] = '{"new_x", "new_y", "new_z", "new_w",
                                 "deriv_out", "scale_out", "color_out"};

    abox_4d_fold_iteration dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("abox_4d_fold_iteration_tb: FAIL");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Truncated unsigned Q16 product, capped.
    function automatic longint unsigned umul_trunc(longint unsigned a, longint unsigned f,
                                                    longint unsigned cap);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, f}) >> 16;
        return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function automatic longint smul_trunc(longint a, longint b, longint unsigned cap);
        longint unsigned m;
        m = umul_trunc(a < 0 ? -a : a, b < 0 ? -b : b, cap);
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [DW-1:0] fold_iteration(logic [DW-1:0] d);
        longint          pt[4];
        longint          z, f, sc, sabs, v, s_in;
        longint unsigned add, rr, factor, deriv, color;
        logic [127:0]    sum;
        bit              sphere;
        logic [DW-1:0]   r;
        s_in = longint'(signed'(d[168 +: 32]));
        sc = sat32(base_scale_reg
                   + smul_trunc(scale_vary_reg, (s_in < 0 ? -s_in : s_in) - 65536,
                                64'h100_0000_0000));
        add = 0;
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            z = longint'(signed'(d[32*k +: 32]));
            if (z > longint'(lim_reg))
                f = 2 * longint'(lim_reg) - z;
            else if (z < -longint'(lim_reg))
                f = -2 * longint'(lim_reg) - z;
            else
                f = z;
            if (f != z)
                add += col_fold_reg;
            pt[k] = sat32(f);
            sum += 128'(pt[k] * pt[k]);
        end
        if (sum > 128'hFFFF_FFFF_FFFF_FFFF)
            sum = 128'hFFFF_FFFF_FFFF_FFFF;
        rr = sum[63:0] >> 16;
        sphere = 1'b0;
        factor = 0;
        if (rr < min_r2_reg)
        begin
            sphere = 1'b1;
            factor = (fixed_r2_reg << 16) / min_r2_reg;
            add += col_inner_reg;
        end
        else if (rr < fixed_r2_reg)
        begin
            sphere = 1'b1;
            factor = (fixed_r2_reg << 16) / (rr == 0 ? 1 : rr);
            add += col_outer_reg;
        end
        for (int k = 0; k < 4; k++)
        begin
            v = pt[k];
            if (sphere)
                v = sat32(smul_trunc(v, longint'(factor), 64'h8000_0000));
            r[32*k +: 32] = 32'(sat32(smul_trunc(v, sc, 64'h8000_0000)));
        end
        deriv = d[128 +: 40];
        if (sphere)
            deriv = umul_trunc(deriv, factor, DERIV_MAX);
        sabs = sc < 0 ? -sc : sc;
        deriv = umul_trunc(deriv, sabs, DERIV_MAX);
        deriv = (deriv > DERIV_MAX - 65536) ? DERIV_MAX : deriv + 65536;
        color = longint'(d[200 +: 32]) + add;
        if (color > 64'hFFFF_FFFF)
            color = 64'hFFFF_FFFF;
        r[128 +: 40] = deriv[39:0];
        r[168 +: 32] = 32'(sc);
        r[200 +: 32] = color[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= 30)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (iteration_q.size() == 0)
                report_mismatch("unexpected item", 64'(m_tdata[63:0]), 64'd0);
            else
            begin
                logic [DW-1:0] want;
                want = iteration_q.pop_front();
                for (int k = 0; k < 7; k++)
                    if ((m_tdata[fld_lo[k] +: 40] ^ want[fld_lo[k] +: 40])
                        & ((40'd1 << fld_w[k]) - 40'd1))
                        report_mismatch(fld_name[k],
                                        64'(m_tdata[fld_lo[k] +: 40]) & ((64'd1 << fld_w[k]) - 1),
                                        64'(want[fld_lo[k] +: 40]) & ((64'd1 << fld_w[k]) - 1));
            end
        end
    end

    // Output side: random stalls, a forced long hold on request.
    initial
    begin
        int len;
        m_tready <= 1'b1;
        forever
        begin
            if (hold_req > 0)
            begin
                len = hold_req;
                hold_req = 0;
            end
            else if (receiver_steady)
                len = 0;
            else if ($urandom_range(0, 99) < 70)
                len = 0;
            else if ($urandom_range(0, 99) < 90)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(15, 60);
            if (len > 0)
            begin
                m_tready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FOLD_LIMIT:  lim_reg        = val[30:0];
            REG_MIN_R2:      min_r2_reg     = val[30:0];
            REG_FIXED_R2:    fixed_r2_reg   = val[30:0];
            REG_BASE_SCALE:  base_scale_reg = longint'(signed'(val));
            REG_SCALE_VARY:  scale_vary_reg = longint'(signed'(val));
            REG_COLOR_FOLD:  col_fold_reg   = val[30:0];
            REG_COLOR_INNER: col_inner_reg  = val[30:0];
            REG_COLOR_OUTER: col_outer_reg  = val[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] lim, logic [31:0] mn, logic [31:0] fx,
                             logic [31:0] bs, logic [31:0] sv, logic [31:0] cf,
                             logic [31:0] ci, logic [31:0] co);
        write_reg(REG_FOLD_LIMIT, lim);
        write_reg(REG_MIN_R2, mn);
        write_reg(REG_FIXED_R2, fx);
        write_reg(REG_BASE_SCALE, bs);
        write_reg(REG_SCALE_VARY, sv);
        write_reg(REG_COLOR_FOLD, cf);
        write_reg(REG_COLOR_INNER, ci);
        write_reg(REG_COLOR_OUTER, co);
    endtask

    task automatic send_item(logic [DW-1:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        iteration_q.push_back(fold_iteration(d));
        if (sender_steady || $urandom_range(0, 99) < 60)
            gap = 0;
        else if ($urandom_range(0, 99) < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (iteration_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [DW-1:0] pack_item(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z, logic [31:0] w,
                                                 logic [39:0] dv, logic [31:0] sc,
                                                 logic [31:0] co);
        return {co, sc, dv, w, z, y, x};
    endfunction

    // Coordinate near the interesting range: mostly around the fold limit, sometimes fully random.
    function automatic logic [31:0] near_coord();
        longint span;
        span = longint'(lim_reg) * 3 + 200000;
        if (span > 64'sd2147483647)
            span = 64'sd2147483647;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'(longint'(lim_reg) + $urandom_range(0, 3) - 1);
            2:       return 32'(-longint'(lim_reg) - $urandom_range(0, 3) + 1);
            default: return 32'($urandom_range(0, 32'(2 * span)) - span);
        endcase
    endfunction

    function automatic logic [DW-1:0] random_item();
        logic [39:0] dv;
        logic [31:0] sc;
        dv = $urandom_range(0, 3) == 0 ? 40'({$urandom, $urandom})
                                       : 40'($urandom_range(0, 1 << 22));
        sc = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 6 << 16) - (3 << 16));
        return pack_item(near_coord(), near_coord(), near_coord(), near_coord(), dv, sc,
                         $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1 << 20));
    endfunction

    task automatic random_config();
        logic [31:0] mn, fx;
        mn = $urandom_range(0, 5) == 0 ? 32'd0 : $urandom_range(1, 1 << 16);
        fx = 32'($urandom_range(1, 1 << 17)) + mn;
        write_all($urandom_range(0, 2) == 0 ? $urandom_range(0, 1 << 31) : $urandom_range(1, 1 << 18),
                  mn, fx,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 << 16) - (1 << 16),
                  $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1 << 17),
                  $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1 << 17),
                  $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1 << 17));
    endtask

    task automatic test_defaults;
        send_item(pack_item(0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            40'hFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_item(pack_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            40'hFF_FFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0));
        send_item(pack_item(32'h0001_0001, 32'hFFFE_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                            40'h1_0000, 32'h0001_0000, 32'h0));
        send_item(pack_item(32'h0000_2000, 32'hFFFF_E000, 0, 0, 40'h1_0000, 32'hFFFF_0000, 0));
        send_item(pack_item(32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000, 0, 40'h3_0000,
                            32'h0002_0000, 32'h100));
        send_item(pack_item(32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'hFFFE_8000,
                            40'h12_3456_789A, 32'h5555_5555, 32'hAAAA_AAAA));
        drain();
    endtask

    task automatic test_config_extremes;
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(pack_item(0, 0, 0, 0, 40'hFF_FFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_item(pack_item(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF, 40'd1,
                            32'h7FFF_FFFF, 0));
        send_item(pack_item(32'h0010_0000, 0, 0, 0, 40'h1_0000, 32'h0001_0000, 0));
        drain();
        // Zero inner radius: the zero-length point takes the outer case.
        write_all(0, 0, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_item(pack_item(0, 0, 0, 0, 40'h1_0000, 32'h0001_0000, 5));
        send_item(pack_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 40'hFF_FFFF_FFFF,
                            32'h8000_0000, 0));
        send_item(pack_item(1, 32'hFFFF_FFFF, 0, 0, 40'd7, 32'h7FFF_FFFF, 0));
        drain();
        write_all(32'h0001_0000, 0, 32'h0004_0000, 32'hFFFE_0000, 32'h0000_8000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(pack_item(0, 0, 0, 0, 40'h1_0000, 0, 32'hFFFF_0000));
        send_item(pack_item(32'h0000_0100, 0, 0, 0, 40'h1_0000, 32'h0003_0000, 0));
        send_item(pack_item(32'h0002_0000, 32'hFFFE_0000, 32'h0002_0000, 32'hFFFE_0000,
                            40'h8_0000, 32'hFFFD_0000, 32'hFFFF_FFFF));
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
                write_all(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'h0002_0000,
                          0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
            else
                random_config();
            sender_steady   = (ph % 4 == 1);
            receiver_steady = (ph % 4 == 2);
            repeat (100)
                send_item(random_item());
            drain();
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_backpressure;
        random_config();
        sender_steady = 1'b1;
        hold_req = 300;
        repeat (100)
            send_item(random_item());
        sender_steady = 1'b0;
        drain();
    endtask

    initial
    begin
        err_count = 0;
        hold_req = 0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        lim_reg = 65536;
        min_r2_reg = 16384;
        fixed_r2_reg = 65536;
        base_scale_reg = 131072;
        scale_vary_reg = 0;
        col_fold_reg = 65536;
        col_inner_reg = 65536;
        col_outer_reg = 65536;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_config_extremes();
        test_random_phases();
        test_backpressure();

        if (err_count == 0)
            $display("abox_4d_fold_iteration_tb: PASS");
        else
            $display("abox_4d_fold_iteration_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/abox_pkg.sv
rtl/core/abox_div.sv
rtl/core/abox_4d_fold_iteration.sv
sim/abox_4d_fold_iteration_tb.sv
